[rtl/core/aes128_pkg.sv]
// Package for the AES-128 encryption pipeline: S-box, GF(2^8) helpers and
// the round functions shared by the top level. No dependencies.
`default_nettype none
package aes128_pkg;

   localparam int ROUNDS = 10;
   localparam int BLOCK_WIDTH = 128;
   localparam int HALF_WIDTH = 64;
   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW = 1'b1;

   typedef logic [BLOCK_WIDTH-1:0] block_type;
   typedef logic [7:0] byte_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic byte_type xtime(input byte_type v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of the block sits at bits [127-8i -: 8].
   function automatic byte_type get_byte(input block_type b, input int i);
      return b[BLOCK_WIDTH-1-8*i -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[BLOCK_WIDTH-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
         end
      end
      return t;
   endfunction

   function automatic block_type mix_columns(input block_type s);
      block_type t;
      byte_type a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         all = a0 ^ a1 ^ a2 ^ a3;
         t[BLOCK_WIDTH-1-8*(4*c) -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[BLOCK_WIDTH-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[BLOCK_WIDTH-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[BLOCK_WIDTH-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   function automatic block_type next_round_key(input block_type k, input byte_type rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   localparam logic [7:0] RCON [ROUNDS] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

endpackage
`default_nettype wire

[rtl/core/aes128_encrypt_top.sv]
// AES-128 encryption, one pipeline stage per round.
// Depends on aes128_pkg for the S-box and the round functions.
//
// Usage: write the key with csr_write (index 0 high half, index 1 low half)
// while the block is idle. Plaintext items arrive on req_valid/req_stall and
// ciphertext items leave on rsp_valid/rsp_stall.
// From acceptance to rsp_valid an item passes eleven register stages: the
// initial key addition and each of the ten rounds take one register stage,
// the first of which is loaded at the accepting edge, and the round keys are
// expanded in a parallel pipeline that travels with the item.
// Throughput is one item per cycle while the receiver takes results.
// When rsp_stall is high the result and the unbroken run of full stages behind
// it stay put, while stages behind an empty one still move; req_stall is high
// only when all eleven stages hold items and the receiver stalls.
// Reset clears all valid bits and sets the key to zero.
`default_nettype none
module aes128_encrypt_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write,
   input  wire logic csr_index,
   input  wire logic [aes128_pkg::HALF_WIDTH-1:0] csr_data,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [aes128_pkg::HALF_WIDTH-1:0] req_plain_high,
   input  wire logic [aes128_pkg::HALF_WIDTH-1:0] req_plain_low,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [aes128_pkg::HALF_WIDTH-1:0] rsp_cipher_high,
   output logic [aes128_pkg::HALF_WIDTH-1:0] rsp_cipher_low
);
   import aes128_pkg::*;

   logic [HALF_WIDTH-1:0] key_high_ff, key_low_ff;
   logic valid_ff [ROUNDS+1];
   block_type state_ff [ROUNDS+1];
   block_type rkey_ff [ROUNDS+1];
   logic advance [ROUNDS+1];

   // A stage moves when the one after it is free or also moves.
   always_comb begin
      advance[ROUNDS] = !valid_ff[ROUNDS] || !rsp_stall;
      for (int i = ROUNDS-1; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
   end

   assign req_stall = !advance[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_KEY_HIGH) begin
            key_high_ff <= csr_data;
         end else begin
            key_low_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= ROUNDS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (advance[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i <= ROUNDS; i++) begin
            if (advance[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         state_ff[0] <= {req_plain_high, req_plain_low} ^ {key_high_ff, key_low_ff};
         rkey_ff[0] <= {key_high_ff, key_low_ff};
      end
      for (int i = 1; i <= ROUNDS; i++) begin
         if (advance[i]) begin
            rkey_ff[i] <= next_round_key(rkey_ff[i-1], RCON[i-1]);
            if (i == ROUNDS) begin
               state_ff[i] <= sub_shift(state_ff[i-1])
                  ^ next_round_key(rkey_ff[i-1], RCON[i-1]);
            end else begin
               state_ff[i] <= mix_columns(sub_shift(state_ff[i-1]))
                  ^ next_round_key(rkey_ff[i-1], RCON[i-1]);
            end
         end
      end
   end

   assign rsp_valid = valid_ff[ROUNDS];
   assign rsp_cipher_high = state_ff[ROUNDS][BLOCK_WIDTH-1:HALF_WIDTH];
   assign rsp_cipher_low = state_ff[ROUNDS][HALF_WIDTH-1:0];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cipher_high))
      else $error("result changed while stalled");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_stall && rsp_valid)
      else $error("input stalled without output back-pressure");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall && valid_ff[ROUNDS-1] |=> rsp_valid)
      else $error("item lost at last stage");

endmodule
`default_nettype wire
